FILE: rtl/bemf_zero_cross_commutator_top_defines.svh
// assertion macros for the back-emf zero-cross commutator
`ifndef BEMF_ZERO_CROSS_COMMUTATOR_TOP_DEFINES_SVH
`define BEMF_ZERO_CROSS_COMMUTATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BZC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bzc same-cycle check failed");
`define BZC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bzc next-cycle check failed");
`else
`define BZC_ASSERT_IMP(lbl, ante, cons)
`define BZC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/bzc_pkg.sv
// shared types and constants for the back-emf zero-cross commutator
package bzc_pkg;

  typedef enum logic [1:0] {
    DET_ARM  = 2'd0,
    DET_HIGH = 2'd1,
    DET_FALL = 2'd2
  } det_state_e;

  typedef struct packed {
    logic [2:0] sector;
    logic       commutate;
    logic [2:0] pending;
  } bzc_status_t;

  localparam logic [1:0] CFG_SENSORLESS = 2'd0;
  localparam logic [1:0] CFG_HF_FLOOR   = 2'd1;
  localparam logic [1:0] CFG_LOW_FILTER = 2'd2;

  localparam logic [7:0] HF_FLOOR_RESET   = 8'd10;
  localparam logic [7:0] LOW_FILTER_RESET = 8'd3;
  localparam logic [7:0] HF_RESET         = 8'd10;
  localparam logic [7:0] CNT_MAX          = 8'hFF;

  localparam logic [2:0] SECTOR_NONE = 3'd0;
  localparam logic [2:0] FIRST_CODE  [3] = '{3'd1, 3'd2, 3'd4};
  localparam logic [2:0] SECOND_CODE [3] = '{3'd3, 3'd6, 3'd5};

endpackage

FILE: rtl/bzc_neutral.sv
// neutral level stage: registered (a+b+c)/3 by reciprocal multiply
module bzc_neutral #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] sample_a_i,
  input  logic [SAMPLE_BITS-1:0] sample_b_i,
  input  logic [SAMPLE_BITS-1:0] sample_c_i,
  output logic [SAMPLE_BITS-1:0] neutral_o
);
  localparam int SumBits  = SAMPLE_BITS + 2;
  localparam int Shift    = SumBits + 1;
  localparam int ProdBits = SumBits + Shift - 1;
  // ceil(2^Shift / 3); error term stays below 2^Shift for any sum
  localparam logic [Shift-2:0] Recip = (Shift-1)'((2 ** Shift + 2) / 3);

  logic [SumBits-1:0]  sum;
  logic [ProdBits-1:0] prod;

  assign sum  = SumBits'(sample_a_i) + SumBits'(sample_b_i) + SumBits'(sample_c_i);
  assign prod = ProdBits'(sum) * ProdBits'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neutral_o <= prod[Shift +: SAMPLE_BITS];
    end
  end
endmodule

FILE: rtl/bzc_detector.sv
// per-phase zero-crossing detector: sustained high, then filtered fall
module bzc_detector #(
  parameter int SAMPLE_BITS = 12,
  parameter int HF_BITS     = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] neutral_i,
  input  logic [HF_BITS-1:0]     high_filter_i,
  input  logic [7:0]             low_filter_i,
  output logic                   hit_o
);
  import bzc_pkg::*;

  det_state_e state_q, state_d;
  logic [7:0] above_q, above_d, below_q, below_d;
  logic [7:0] above_inc, below_inc;
  logic       is_above, is_below;

  assign is_above  = sample_i > neutral_i;
  assign is_below  = sample_i < neutral_i;
  assign above_inc = (above_q == CNT_MAX) ? above_q : above_q + 8'd1;
  assign below_inc = (below_q == CNT_MAX) ? below_q : below_q + 8'd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      DET_ARM: begin
        if (is_above && (HF_BITS'(above_inc) > high_filter_i)) state_d = DET_HIGH;
      end
      DET_HIGH: begin
        if (is_below) state_d = DET_FALL;
      end
      DET_FALL: begin
        if (is_below) begin
          if (below_inc > low_filter_i) state_d = DET_ARM;
        end else begin
          state_d = DET_HIGH;
        end
      end
      default: state_d = DET_ARM;
    endcase
  end

  always_comb begin
    above_d = above_q;
    below_d = below_q;
    hit_o   = 1'b0;
    case (state_q)
      DET_ARM: begin
        above_d = is_above ? above_inc : 8'd0;
      end
      DET_HIGH: begin
        if (is_below) below_d = 8'd0;
      end
      DET_FALL: begin
        if (is_below) begin
          below_d = below_inc;
          if (below_inc > low_filter_i) begin
            above_d = 8'd0;
            hit_o   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DET_ARM;
      above_q <= 8'd0;
      below_q <= 8'd0;
    end else if (en_i) begin
      state_q <= state_d;
      above_q <= above_d;
      below_q <= below_d;
    end
  end
endmodule

FILE: rtl/bzc_timing.sv
// high filter tracking, period summing, commutation timer and sector choice
module bzc_timing #(
  parameter int COUNT_BITS = 16,
  parameter int HF_BITS    = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [2:0]           high_side_i,
  input  logic                 sensorless_en_i,
  input  logic [7:0]           hf_floor_i,
  input  logic [2:0]           hit_i,
  output logic [HF_BITS-1:0]   high_filter_o,
  output bzc_pkg::bzc_status_t status_o
);
  import bzc_pkg::*;

  localparam int SumBits = COUNT_BITS + 1;

  logic [2:0]            last_hs_q;
  logic [COUNT_BITS-1:0] chg_q, chg_d, chg_base;
  logic [HF_BITS-1:0]    hf_q, hf_d, hf_cand, floor_ext;
  logic [COUNT_BITS-1:0] per_q, per_d, per_inc;
  logic [SumBits-1:0]    sum_q, sum_d, sum_new;
  logic                  sev_q, sev_d;
  logic [COUNT_BITS-1:0] cc_q, cc_d, cc_base, cc_inc;
  logic [COUNT_BITS-1:0] lim_q, lim_d;
  logic [2:0]            sector_q, sector_d;
  logic [2:0]            pend_q, pend_d, pend_mid;
  logic [2:0]            served_q, served_d, served_mid;
  logic                  hs_change, expire, fire, found;

  assign hs_change = high_side_i != last_hs_q;
  assign hf_cand   = HF_BITS'(chg_q >> 2);
  assign floor_ext = HF_BITS'(hf_floor_i);
  assign hf_d      = hs_change ? ((hf_cand < floor_ext) ? floor_ext : hf_cand) : hf_q;
  assign chg_base  = hs_change ? '0 : chg_q;
  assign chg_d     = chg_base + COUNT_BITS'(1);
  assign high_filter_o = hf_d;

  assign per_inc = per_q + COUNT_BITS'(1);
  assign sum_new = sum_q + SumBits'(per_inc);

  // every second detection closes the period sum
  always_comb begin
    per_d   = per_inc;
    sum_d   = sum_q;
    sev_d   = sev_q;
    cc_base = cc_q;
    lim_d   = lim_q;
    if (|hit_i) begin
      per_d = '0;
      if (sev_q) begin
        sev_d   = 1'b0;
        cc_base = COUNT_BITS'(sum_new >> 3);
        lim_d   = COUNT_BITS'(sum_new >> 2);
        sum_d   = '0;
      end else begin
        sev_d = 1'b1;
        sum_d = sum_new;
      end
    end
  end

  assign cc_inc     = cc_base + COUNT_BITS'(1);
  assign expire     = cc_inc >= lim_d;
  assign cc_d       = expire ? '0 : cc_inc;
  assign fire       = expire && sensorless_en_i;
  assign pend_mid   = pend_q | hit_i;
  assign served_mid = served_q & ~hit_i;

  // lowest pending phase wins: first visit gives its first code, second clears it
  always_comb begin
    sector_d = sector_q;
    pend_d   = pend_mid;
    served_d = served_mid;
    found    = 1'b0;
    if (fire) begin
      sector_d = SECTOR_NONE;
      for (int p = 0; p < 3; p++) begin
        if (!found && pend_mid[p]) begin
          found = 1'b1;
          if (!served_mid[p]) begin
            served_d[p] = 1'b1;
            sector_d    = FIRST_CODE[p];
          end else begin
            pend_d[p] = 1'b0;
            sector_d  = SECOND_CODE[p];
          end
        end
      end
    end
  end

  assign status_o.sector    = sector_d;
  assign status_o.commutate = fire;
  assign status_o.pending   = pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hs_q <= 3'd0;
      chg_q     <= '0;
      hf_q      <= HF_BITS'(HF_RESET);
      per_q     <= '0;
      sum_q     <= '0;
      sev_q     <= 1'b0;
      cc_q      <= '0;
      lim_q     <= '0;
      sector_q  <= SECTOR_NONE;
      pend_q    <= 3'd0;
      served_q  <= 3'd0;
    end else if (en_i) begin
      last_hs_q <= high_side_i;
      chg_q     <= chg_d;
      hf_q      <= hf_d;
      per_q     <= per_d;
      sum_q     <= sum_d;
      sev_q     <= sev_d;
      cc_q      <= cc_d;
      lim_q     <= lim_d;
      sector_q  <= sector_d;
      pend_q    <= pend_d;
      served_q  <= served_d;
    end
  end
endmodule

FILE: rtl/bemf_zero_cross_commutator_top.sv
// top level of the sensorless back-emf zero-cross commutator
//
//  channel  direction  contents
//  s_axis   in         three phase samples and high-side enables, one tick per transaction
//  m_axis   out        sector, commutate, neutral level, pending flags
//  cfg      in         register index and write data
//
// three register stages: input register, neutral register (divide by three
// multiply), result register where all detector and timer state advances.
// one tick per cycle sustained while the output is not stalled; the result
// passes the input, neutral and result registers in turn.
// reset clears all control and timer state; config resets to its defaults.
// a stalled result holds the pipeline behind it only where stages are full.
`include "bemf_zero_cross_commutator_top_defines.svh"

module bemf_zero_cross_commutator_top #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16,
  localparam int InBits     = ((3 * SAMPLE_BITS + 3 + 7) / 8) * 8,
  localparam int OutBits    = ((SAMPLE_BITS + 7 + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // phase_a_sample, phase_b_sample, phase_c_sample, high_side_now
  input  logic [InBits-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // sector, commutate, neutral_level, pending_flags
  output logic [OutBits-1:0] m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_addr_i,
  input  logic [7:0]         cfg_wdata_i
);
  import bzc_pkg::*;

  localparam int HfBits = (COUNT_BITS - 2 > 8) ? COUNT_BITS - 2 : 8;
  localparam int Sb     = SAMPLE_BITS;

  logic             sensorless_en_q;
  logic [7:0]       hf_floor_q, low_filter_q;
  logic             v1_q, v2_q, vo_q;
  logic             acc, adv1, adv2, out_free, r2;
  logic [Sb-1:0]    s1_q [3];
  logic [Sb-1:0]    s2_q [3];
  logic [2:0]       hs1_q, hs2_q;
  logic [Sb-1:0]    neutral;
  logic [HfBits-1:0] high_filter;
  logic [2:0]       hit;
  bzc_status_t      status;
  bzc_status_t      res_q;
  logic [Sb-1:0]    res_neutral_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensorless_en_q <= 1'b0;
      hf_floor_q      <= HF_FLOOR_RESET;
      low_filter_q    <= LOW_FILTER_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_SENSORLESS: sensorless_en_q <= cfg_wdata_i[0];
        CFG_HF_FLOOR:   hf_floor_q      <= cfg_wdata_i;
        CFG_LOW_FILTER: low_filter_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // each stage moves on when the one after it is empty or moving
  assign out_free      = !vo_q || m_axis_tready;
  assign adv2          = v2_q && out_free;
  assign r2            = !v2_q || adv2;
  assign adv1          = v1_q && r2;
  assign s_axis_tready = !v1_q || adv1;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (acc) v1_q <= 1'b1;
      else if (adv1) v1_q <= 1'b0;
      if (adv1) v2_q <= 1'b1;
      else if (adv2) v2_q <= 1'b0;
      if (adv2) vo_q <= 1'b1;
      else if (m_axis_tready) vo_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q[0] <= s_axis_tdata[0 +: Sb];
      s1_q[1] <= s_axis_tdata[Sb +: Sb];
      s1_q[2] <= s_axis_tdata[2*Sb +: Sb];
      hs1_q   <= s_axis_tdata[3*Sb +: 3];
    end
    if (adv1) begin
      s2_q  <= s1_q;
      hs2_q <= hs1_q;
    end
    if (adv2) begin
      res_q         <= status;
      res_neutral_q <= neutral;
    end
  end

  bzc_neutral #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_neutral (
    .clk_i      (clk_i),
    .en_i       (adv1),
    .sample_a_i (s1_q[0]),
    .sample_b_i (s1_q[1]),
    .sample_c_i (s1_q[2]),
    .neutral_o  (neutral)
  );

  for (genvar p = 0; p < 3; p++) begin : g_phase
    bzc_detector #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .HF_BITS    (HfBits)
    ) u_detector (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (adv2),
      .sample_i      (s2_q[p]),
      .neutral_i     (neutral),
      .high_filter_i (high_filter),
      .low_filter_i  (low_filter_q),
      .hit_o         (hit[p])
    );
  end

  bzc_timing #(
    .COUNT_BITS(COUNT_BITS),
    .HF_BITS   (HfBits)
  ) u_timing (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv2),
    .high_side_i     (hs2_q),
    .sensorless_en_i (sensorless_en_q),
    .hf_floor_i      (hf_floor_q),
    .hit_i           (hit),
    .high_filter_o   (high_filter),
    .status_o        (status)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OutBits'({res_q.pending, res_neutral_q, res_q.commutate,
                                   res_q.sector});

  `BZC_ASSERT_IMP(a_ready_when_out_empty, !vo_q, s_axis_tready)
  `BZC_ASSERT_IMP(a_commutate_needs_enable, vo_q && res_q.commutate, sensorless_en_q)
  `BZC_ASSERT_IMP(a_none_means_nothing_pending,
                  vo_q && res_q.commutate && (res_q.sector == SECTOR_NONE),
                  res_q.pending == 3'd0)
  `BZC_ASSERT_NXT(a_cfg_enable_written,
                  cfg_valid_i && (cfg_addr_i == CFG_SENSORLESS),
                  sensorless_en_q == $past(cfg_wdata_i[0]))
endmodule

FILE: tb/sv/bemf_zero_cross_commutator_top_test.sv
// self-checking testbench for the back-emf zero-cross commutator top level
`timescale 1ns / 1ps

module bemf_zero_cross_commutator_top_test;
  import bzc_pkg::*;

  localparam int IN_W            = 40;
  localparam int OUT_W           = 24;
  localparam int SUMS_PER_PERIOD = 2;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 240;
  localparam int STALL_LIMIT     = 3000;

  typedef struct packed {
    bit [11:0] a;
    bit [11:0] b;
    bit [11:0] c;
    bit [2:0]  hs;
  } tick_t;

  typedef struct packed {
    bit [2:0]  sector;
    bit        commutate;
    bit [11:0] neutral;
    bit [2:0]  pending;
  } status_t;

  // tracks detector and timer state tick by tick and holds the statuses still owed
  class commutation_tracker;
    bit         enable;
    bit [7:0]   hf_floor;
    bit [7:0]   low_filt;
    bit [2:0]   last_hs;
    bit [15:0]  change_ticks;
    bit [13:0]  hi_filter;
    det_state_e det [3];
    bit [7:0]   above_cnt [3];
    bit [7:0]   below_cnt [3];
    bit         pend [3];
    bit         second_done [3];
    bit [15:0]  period_ticks;
    bit [16:0]  period_acc;
    bit [1:0]   acc_events;
    bit [15:0]  comm_count;
    bit [15:0]  comm_limit;
    bit [2:0]   sector_now;
    status_t    predicted_status [$];
    int         faults;

    function new();
      int p;
      enable       = 1'b0;
      hf_floor     = HF_FLOOR_RESET;
      low_filt     = LOW_FILTER_RESET;
      last_hs      = '0;
      change_ticks = '0;
      hi_filter    = 14'(HF_RESET);
      for (p = 0; p < 3; p++) begin
        det[p]         = DET_ARM;
        above_cnt[p]   = '0;
        below_cnt[p]   = '0;
        pend[p]        = 1'b0;
        second_done[p] = 1'b0;
      end
      period_ticks = '0;
      period_acc   = '0;
      acc_events   = '0;
      comm_count   = '0;
      comm_limit   = '0;
      sector_now   = SECTOR_NONE;
      faults       = 0;
    endfunction

    function void load_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_SENSORLESS: enable   = val[0];
        CFG_HF_FLOOR:   hf_floor = val;
        CFG_LOW_FILTER: low_filt = val;
        default: ;
      endcase
    endfunction

    function void note_tick(tick_t t);
      int unsigned nsum;
      bit [11:0]   neutral;
      bit [11:0]   smp [3];
      bit          hit;
      bit          fire;
      bit          found;
      int          p;
      status_t     r;
      smp[0] = t.a;
      smp[1] = t.b;
      smp[2] = t.c;
      nsum = 32'(t.a) + 32'(t.b) + 32'(t.c);
      neutral = 12'(nsum / 3);
      if (t.hs != last_hs) begin
        hi_filter = change_ticks[15:2];
        if (hi_filter < 14'(hf_floor)) hi_filter = 14'(hf_floor);
        change_ticks = '0;
        last_hs = t.hs;
      end
      change_ticks++;

      hit = 1'b0;
      for (p = 0; p < 3; p++) begin
        case (det[p])
          DET_ARM: begin
            if (smp[p] > neutral) begin
              if (above_cnt[p] != CNT_MAX) above_cnt[p]++;
              if (14'(above_cnt[p]) > hi_filter) det[p] = DET_HIGH;
            end else begin
              above_cnt[p] = '0;
            end
          end
          DET_HIGH: begin
            if (smp[p] < neutral) begin
              det[p] = DET_FALL;
              below_cnt[p] = '0;
            end
          end
          DET_FALL: begin
            if (smp[p] < neutral) begin
              if (below_cnt[p] != CNT_MAX) below_cnt[p]++;
              if (below_cnt[p] > low_filt) begin
                det[p] = DET_ARM;
                pend[p] = 1'b1;
                second_done[p] = 1'b0;
                above_cnt[p] = '0;
                hit = 1'b1;
              end
            end else begin
              det[p] = DET_HIGH;
            end
          end
          default: det[p] = DET_ARM;
        endcase
      end

      period_ticks++;
      if (hit) begin
        period_acc = period_acc + 17'(period_ticks);
        acc_events++;
        if (acc_events >= 2'(SUMS_PER_PERIOD)) begin
          acc_events = '0;
          comm_count = 16'(period_acc >> 3);
          comm_limit = 16'(period_acc >> 2);
          period_acc = '0;
        end
        period_ticks = '0;
      end

      comm_count++;
      fire = 1'b0;
      if (comm_count >= comm_limit) begin
        comm_count = '0;
        if (enable) begin
          fire = 1'b1;
          sector_now = SECTOR_NONE;
          found = 1'b0;
          // lowest pending phase wins, first its early code then its late code
          for (p = 0; p < 3 && !found; p++) begin
            if (pend[p]) begin
              found = 1'b1;
              if (!second_done[p]) begin
                second_done[p] = 1'b1;
                sector_now = FIRST_CODE[p];
              end else begin
                pend[p] = 1'b0;
                sector_now = SECOND_CODE[p];
              end
            end
          end
        end
      end

      r.sector    = sector_now;
      r.commutate = fire;
      r.neutral   = neutral;
      r.pending   = {pend[2], pend[1], pend[0]};
      predicted_status.push_back(r);
    endfunction

    function void check_status(logic [OUT_W-1:0] d);
      status_t want;
      if (predicted_status.size() == 0) begin
        $error("status transaction with nothing predicted: %h", d);
        faults++;
        return;
      end
      want = predicted_status.pop_front();
      if (d[2:0] !== want.sector) begin
        $error("sector: expected %0d, actual %0d", want.sector, d[2:0]);
        faults++;
      end
      if (d[3] !== want.commutate) begin
        $error("commutate: expected %0d, actual %0d", want.commutate, d[3]);
        faults++;
      end
      if (d[15:4] !== want.neutral) begin
        $error("neutral_level: expected %0d, actual %0d", want.neutral, d[15:4]);
        faults++;
      end
      if (d[18:16] !== want.pending) begin
        $error("pending_flags: expected %0d, actual %0d", want.pending, d[18:16]);
        faults++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // phase_a_sample, phase_b_sample, phase_c_sample, high_side_now
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // sector, commutate, neutral_level, pending_flags
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_addr_i;
  logic [7:0]       cfg_wdata_i;

  commutation_tracker tracker = new();

  int       send_idle_pct = 35;
  int       recv_idle_pct = 71;
  bit       hold_req = 1'b0;
  int       ticks_sent = 0;
  bit [2:0] hs_now = '0;
  bit [7:0] cur_floor = HF_FLOOR_RESET;
  bit [7:0] cur_low = LOW_FILTER_RESET;

  bemf_zero_cross_commutator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tick_t tick_of(bit [11:0] a, bit [11:0] b, bit [11:0] c, bit [2:0] hs);
    tick_t t;
    t.a  = a;
    t.b  = b;
    t.c  = c;
    t.hs = hs;
    return t;
  endfunction

  function automatic tick_t noise_tick();
    return tick_of(12'($urandom), 12'($urandom), 12'($urandom), 3'($urandom));
  endfunction

  // phase p clearly above neutral (up) or clearly below it, the others random on the far side
  function automatic tick_t shaped_tick(int p, bit up, bit [2:0] hs);
    bit [11:0] v [3];
    int        q;
    for (q = 0; q < 3; q++)
      v[q] = up ? 12'($urandom_range(1500, 0)) : 12'($urandom_range(4095, 2000));
    v[p] = up ? 12'($urandom_range(4095, 2600)) : 12'($urandom_range(1000, 0));
    return tick_of(v[0], v[1], v[2], hs);
  endfunction

  task automatic offer_tick(input tick_t t);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t.hs, t.c, t.b, t.a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_tick(t);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.predicted_status.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.load_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input bit en, input bit [7:0] floor_v, input bit [7:0] low_v);
    drain_results();
    put_reg(CFG_SENSORLESS, {7'b0, en});
    put_reg(CFG_HF_FLOOR, floor_v);
    put_reg(CFG_LOW_FILTER, low_v);
    cfg_valid_i <= 1'b0;
    cur_floor = floor_v;
    cur_low   = low_v;
  endtask

  task automatic directed_ticks();
    offer_tick(tick_of(12'd0, 12'd0, 12'd0, 3'd0));
    offer_tick(tick_of(12'd4095, 12'd4095, 12'd4095, 3'd7));
    offer_tick(tick_of(12'd4095, 12'd0, 12'd0, 3'd1));
    offer_tick(tick_of(12'd0, 12'd4095, 12'd0, 3'd2));
    offer_tick(tick_of(12'd0, 12'd0, 12'd4095, 3'd4));
    offer_tick(tick_of(12'd4095, 12'd4095, 12'd0, 3'd3));
    offer_tick(tick_of(12'd0, 12'd4095, 12'd4095, 3'd6));
    offer_tick(tick_of(12'd4095, 12'd0, 12'd4095, 3'd5));
    offer_tick(tick_of(12'hAAA, 12'h555, 12'hAAA, 3'd2));
    offer_tick(tick_of(12'h555, 12'hAAA, 12'h555, 3'd5));
    // samples equal to neutral count as neither above nor below
    offer_tick(tick_of(12'd2048, 12'd2048, 12'd2048, 3'd5));
    offer_tick(tick_of(12'd1, 12'd0, 12'd0, 3'd0));
    offer_tick(tick_of(12'd4093, 12'd4095, 12'd4095, 3'd0));
  endtask

  task automatic random_phase(input int n, input bit stress);
    int  start;
    int  k;
    int  p;
    int  up_reach;
    int  down_reach;
    bit  held;
    bit  paused;
    start  = ticks_sent;
    held   = 1'b0;
    paused = 1'b0;
    up_reach   = (cur_floor >= 8'd200) ? 30 : 2 * int'(cur_floor) + 16;
    down_reach = (cur_low >= 8'd200) ? 12 : int'(cur_low) + 6;
    while (ticks_sent - start < n) begin
      if (stress && !held && ticks_sent - start >= n / 3) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (stress && !paused && ticks_sent - start >= 2 * n / 3) begin
        drain_results();
        paused = 1'b1;
      end
      k = $urandom_range(9, 0);
      p = $urandom_range(2, 0);
      hs_now = ($urandom_range(3, 0) == 0) ? 3'($urandom) : 3'(1 << p);
      if (k == 0) begin
        repeat ($urandom_range(8, 1)) offer_tick(noise_tick());
      end else begin
        repeat ($urandom_range(up_reach, 1)) offer_tick(shaped_tick(p, 1'b1, hs_now));
        if (k == 1) begin
          // fall cut short by a return above neutral
          repeat ($urandom_range(2, 1)) offer_tick(shaped_tick(p, 1'b0, hs_now));
          offer_tick(shaped_tick(p, 1'b1, hs_now));
        end else begin
          repeat ($urandom_range(down_reach, 1)) offer_tick(shaped_tick(p, 1'b0, hs_now));
        end
      end
    end
  endtask

  // receiver side: random stalls plus one long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_status(m_axis_tdata);
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("bemf_zero_cross_commutator_top_test: errors");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CFG_SENSORLESS;
    cfg_wdata_i   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: sensorless off, so instants expire without firing or touching the sector
    directed_ticks();

    program_regs(1'b1, 8'd10, 8'd3);
    random_phase(120, 1'b1);
    program_regs(1'b1, 8'd1, 8'd0);
    random_phase(30, 1'b0);

    send_idle_pct = 71;
    recv_idle_pct = 35;
    program_regs(1'b0, 8'd255, 8'd255);
    // high filter out of reach: the above counter saturates
    hs_now = 3'd2;
    repeat (257) offer_tick(shaped_tick(1, 1'b1, hs_now));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(1'b1, 8'd0, 8'd255);
    // two quick enable changes leave the high filter at zero
    offer_tick(shaped_tick(0, 1'b1, 3'd1));
    offer_tick(shaped_tick(0, 1'b1, 3'd4));
    repeat (4) offer_tick(shaped_tick(0, 1'b1, 3'd4));
    // low filter out of reach: the below counter saturates
    repeat (258) offer_tick(shaped_tick(0, 1'b0, 3'd4));

    drain_results();
    if (tracker.faults == 0 && tracker.predicted_status.size() == 0) begin
      $display("bemf_zero_cross_commutator_top_test: clean");
    end else begin
      $display("bemf_zero_cross_commutator_top_test: errors");
    end
    $finish;
  end

endmodule

FILE: bemf_zero_cross_commutator_top.f
+incdir+rtl
rtl/bzc_pkg.sv
rtl/bzc_neutral.sv
rtl/bzc_detector.sv
rtl/bzc_timing.sv
rtl/bemf_zero_cross_commutator_top.sv
tb/sv/bemf_zero_cross_commutator_top_test.sv
